// ----- hdl/pmgc_pkg.sv -----
`default_nettype none

package pmgc_pkg;

	// Field and datapath widths
	localparam int COORD_W  = 48;
	localparam int AXES     = 3;
	localparam int DIFF_W   = COORD_W + 1;
	localparam int SQ_W     = 2 * DIFF_W;
	localparam int ROOT_W   = DIFF_W;
	localparam int MASS_W   = 24;
	localparam int KGAIN_W  = 60;
	localparam int KG_LO_W  = 30;
	localparam int NUM_W    = MASS_W + KGAIN_W;
	localparam int G_W      = 45;
	localparam int G_LO_W   = 23;
	localparam int U_FRAC   = 30;
	localparam int U_W      = U_FRAC + 1;
	localparam int UNUM_W   = DIFF_W + U_FRAC;
	localparam int PROD_W   = G_W + U_W;
	localparam int INC_W    = PROD_W - U_FRAC;
	localparam int SUM_W    = COORD_W + 2;
	localparam int TDATA_W  = 2 * AXES * COORD_W;
	localparam int CFG_IDX_W = 3;

	// Split of a 49-bit magnitude for squaring
	localparam int AD_LO_W  = 25;

	// Fixed-point constants (units of 2^-24, gain in 2^-72)
	localparam logic [KGAIN_W-1:0] KGAIN    = 60'd944473296573929043;
	localparam logic [KG_LO_W-1:0] KGAIN_LO = KGAIN[KG_LO_W-1:0];
	localparam logic [KGAIN_W-KG_LO_W-1:0] KGAIN_HI = KGAIN[KGAIN_W-1:KG_LO_W];
	localparam logic [SQ_W-1:0]    CAP_R2   = 98'd703687777321;
	localparam logic [SQ_W-1:0]    EPS2     = 98'd28147497671;
	localparam logic [MASS_W-1:0]  MASS_RESET = 24'd1000000;

	localparam logic signed [SUM_W-1:0] VEL_MAX = 50'sh0_7FFF_FFFF_FFFF;
	localparam logic signed [SUM_W-1:0] VEL_MIN = -VEL_MAX - 50'sd1;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENABLE = 3'd0,
		CFG_MASS   = 3'd1,
		CFG_HOLE_X = 3'd2,
		CFG_HOLE_Y = 3'd3,
		CFG_HOLE_Z = 3'd4
	} cfg_idx_t;

	// Star data riding alongside the math
	typedef struct packed {
		logic                          act;
		logic [AXES-1:0]               neg;
		logic [AXES-1:0][COORD_W-1:0]  vel;
		logic [AXES-1:0][COORD_W-1:0]  pos;
	} side_t;

	// One finished star
	typedef struct packed {
		logic                          cap;
		logic [AXES-1:0][COORD_W-1:0]  vel;
		logic [AXES-1:0][COORD_W-1:0]  pos;
	} result_t;

endpackage

`default_nettype wire

// ----- hdl/pmgc_delay.sv -----
`default_nettype none

module pmgc_delay #(
	parameter int W     = 1,
	parameter int DEPTH = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] tap_q [DEPTH];

	// Shift the line one place per advance
	always_ff @(posedge clk) begin
		if (en) begin
			tap_q[0] <= d;
			for (int i = 1; i < DEPTH; i++) begin
				tap_q[i] <= tap_q[i-1];
			end
		end
	end

	assign q = tap_q[DEPTH-1];

endmodule

`default_nettype wire

// ----- hdl/pmgc_isqrt.sv -----
`default_nettype none

// Pipelined integer square root, one root bit per stage, floor result
module pmgc_isqrt #(
	parameter int IN_W   = 98,
	parameter int ROOT_W = 49
) (
	input  logic              clk,
	input  logic              en,
	input  logic [IN_W-1:0]   radicand,
	output logic [ROOT_W-1:0] root
);

	localparam int W = IN_W + 1;

	logic [W-1:0] op_s  [1:ROOT_W];
	logic [W-1:0] res_s [1:ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_step
		localparam logic [W-1:0] ONE = W'(1) << (2 * (ROOT_W - 1 - k));
		logic [W-1:0] op_in;
		logic [W-1:0] res_in;
		logic [W-1:0] trial;
		logic         fits;

		if (k == 0) begin : g_first
			assign op_in  = W'(radicand);
			assign res_in = '0;
		end else begin : g_next
			assign op_in  = op_s[k];
			assign res_in = res_s[k];
		end

		assign trial = res_in + ONE;
		assign fits  = op_in >= trial;

		// Take the bit when the trial fits under the remainder
		always_ff @(posedge clk) begin
			if (en) begin
				op_s[k+1]  <= fits ? op_in - trial : op_in;
				res_s[k+1] <= fits ? (res_in >> 1) + ONE : res_in >> 1;
			end
		end
	end

	assign root = res_s[ROOT_W][ROOT_W-1:0];

endmodule

`default_nettype wire

// ----- hdl/pmgc_div.sv -----
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage.
// The quotient must fit in QUO_W bits (num < den * 2^QUO_W).
module pmgc_div #(
	parameter int NUM_W = 84,
	parameter int DEN_W = 98,
	parameter int QUO_W = 45
) (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [QUO_W-1:0] quo
);

	logic [DEN_W-1:0] rem_s [1:QUO_W];
	logic [DEN_W-1:0] den_s [1:QUO_W];
	logic [QUO_W-1:0] low_s [1:QUO_W];
	logic [QUO_W-1:0] quo_s [1:QUO_W];

	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		logic [DEN_W-1:0] rem_in;
		logic [DEN_W-1:0] den_in;
		logic [QUO_W-1:0] low_in;
		logic [QUO_W-1:0] quo_in;
		logic [DEN_W:0]   trial;
		logic [DEN_W:0]   diff;
		logic             fits;

		if (k == 0) begin : g_first
			assign rem_in = DEN_W'(num >> QUO_W);
			assign den_in = den;
			assign low_in = num[QUO_W-1:0];
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k];
			assign den_in = den_s[k];
			assign low_in = low_s[k];
			assign quo_in = quo_s[k];
		end

		assign trial = {rem_in, low_in[QUO_W-1]};
		assign diff  = trial - {1'b0, den_in};
		assign fits  = trial >= {1'b0, den_in};

		// Subtract when the divisor fits, shift in the quotient bit
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				den_s[k+1] <= den_in;
				low_s[k+1] <= low_in << 1;
				quo_s[k+1] <= {quo_in[QUO_W-2:0], fits};
			end
		end
	end

	assign quo = quo_s[QUO_W];

endmodule

`default_nettype wire

// ----- hdl/point_mass_gravity_capture_step.sv -----
`default_nettype none

// Point-mass gravity step with capture. Each star transfer on the s_ side
// carries position and velocity (signed Q24.24) and galaxy_alive in s_tuser;
// one result per star leaves on the m_ side with captured in m_tuser. The
// block takes one star every clock while the skid register is empty. Its
// pipeline depth is set mostly by the 49-stage square root of r^2 followed
// by the 31-stage cosine dividers, one bit per stage; the gain divider runs
// beside the square root. An output register plus a one-entry skid register
// let a new star enter while a result waits.
// Configuration writes are taken at any edge but must only be made while no
// star is in flight.
module point_mass_gravity_capture_step (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// in_pos_x, in_pos_y, in_pos_z, in_vel_x, in_vel_y, in_vel_z (48 bits each)
	input  logic [pmgc_pkg::TDATA_W-1:0]    s_tdata,
	// galaxy_alive
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// out_pos_x, out_pos_y, out_pos_z, out_vel_x, out_vel_y, out_vel_z (48 bits each)
	output logic [pmgc_pkg::TDATA_W-1:0]    m_tdata,
	// captured
	output logic                            m_tuser,
	input  logic                            cfg_we,
	input  logic [pmgc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pmgc_pkg::COORD_W-1:0]    cfg_data
);

	localparam int AXES    = pmgc_pkg::AXES;
	localparam int CW      = pmgc_pkg::COORD_W;
	localparam int DW      = pmgc_pkg::DIFF_W;
	localparam int ST_R2   = 5;
	localparam int ST_CAP  = 6;
	localparam int ST_ROOT = ST_R2 + pmgc_pkg::ROOT_W;
	localparam int ST_G    = ST_CAP + pmgc_pkg::G_W;
	localparam int ST_U    = ST_ROOT + pmgc_pkg::U_W;
	localparam int ST_INC  = ST_U + 2;
	localparam int LO_W    = pmgc_pkg::AD_LO_W;
	localparam int HI_W    = DW - LO_W;
	localparam int GL_W    = pmgc_pkg::G_LO_W;
	localparam int GH_W    = pmgc_pkg::G_W - GL_W;

	// Configuration registers
	logic                                 enable_q;
	logic [pmgc_pkg::MASS_W-1:0]          mass_q;
	logic [AXES-1:0][CW-1:0]              hole_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
			mass_q   <= pmgc_pkg::MASS_RESET;
			hole_q   <= '0;
		end else if (cfg_we) begin
			case (pmgc_pkg::cfg_idx_t'(cfg_index))
				pmgc_pkg::CFG_ENABLE: enable_q  <= cfg_data[0];
				pmgc_pkg::CFG_MASS:   mass_q    <= cfg_data[pmgc_pkg::MASS_W-1:0];
				pmgc_pkg::CFG_HOLE_X: hole_q[0] <= cfg_data;
				pmgc_pkg::CFG_HOLE_Y: hole_q[1] <= cfg_data;
				pmgc_pkg::CFG_HOLE_Z: hole_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Whole pipeline advances unless the skid register is occupied
	logic en;
	logic sv_q;
	logic ov_q;
	pmgc_pkg::result_t od_q;
	pmgc_pkg::result_t sd_q;

	assign en       = !sv_q;
	assign s_tready = en;

	logic [ST_INC:1] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[ST_INC-1:1], s_tvalid};
		end
	end

	logic [AXES-1:0][CW-1:0] in_pos;
	logic [AXES-1:0][CW-1:0] in_vel;

	assign in_pos = s_tdata[AXES*CW-1:0];
	assign in_vel = s_tdata[2*AXES*CW-1:AXES*CW];

	// Stage 1: offset to the hole
	logic [AXES-1:0][DW-1:0] d_s1;
	logic [AXES-1:0][CW-1:0] pos_s1;
	logic [AXES-1:0][CW-1:0] vel_s1;
	logic                    act_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < AXES; k++) begin
				d_s1[k] <= {hole_q[k][CW-1], hole_q[k]} - {in_pos[k][CW-1], in_pos[k]};
			end
			pos_s1 <= in_pos;
			vel_s1 <= in_vel;
			act_s1 <= enable_q & s_tuser;
		end
	end

	// Stage 2: magnitude and sign of the offset
	logic [AXES-1:0][DW-1:0] ad_s2;
	pmgc_pkg::side_t         side_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < AXES; k++) begin
				ad_s2[k]       <= d_s1[k][DW-1] ? -d_s1[k] : d_s1[k];
				side_s2.neg[k] <= d_s1[k][DW-1];
			end
			side_s2.act <= act_s1;
			side_s2.pos <= pos_s1;
			side_s2.vel <= vel_s1;
		end
	end

	// Stage 3: partial products of the squares and of mass times gain
	logic [AXES-1:0][2*HI_W-1:0]      hh_s3;
	logic [AXES-1:0][HI_W+LO_W-1:0]   hl_s3;
	logic [AXES-1:0][2*LO_W-1:0]      ll_s3;
	logic [pmgc_pkg::MASS_W+pmgc_pkg::KG_LO_W-1:0] mlo_s3;
	logic [pmgc_pkg::NUM_W-pmgc_pkg::KG_LO_W-1:0]  mhi_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < AXES; k++) begin
				hh_s3[k] <= ad_s2[k][DW-1:LO_W] * ad_s2[k][DW-1:LO_W];
				hl_s3[k] <= ad_s2[k][DW-1:LO_W] * ad_s2[k][LO_W-1:0];
				ll_s3[k] <= ad_s2[k][LO_W-1:0] * ad_s2[k][LO_W-1:0];
			end
			mlo_s3 <= mass_q * pmgc_pkg::KGAIN_LO;
			mhi_s3 <= mass_q * pmgc_pkg::KGAIN_HI;
		end
	end

	// Stage 4: assemble each square and the gain numerator
	logic [AXES-1:0][pmgc_pkg::SQ_W-1:0] sq_s4;
	logic [pmgc_pkg::NUM_W-1:0]          num_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < AXES; k++) begin
				sq_s4[k] <= (pmgc_pkg::SQ_W'(hh_s3[k]) << (2 * LO_W))
					+ (pmgc_pkg::SQ_W'(hl_s3[k]) << (LO_W + 1))
					+ pmgc_pkg::SQ_W'(ll_s3[k]);
			end
			num_s4 <= (pmgc_pkg::NUM_W'(mhi_s3) << pmgc_pkg::KG_LO_W)
				+ pmgc_pkg::NUM_W'(mlo_s3);
		end
	end

	// Stage 5: squared distance
	logic [pmgc_pkg::SQ_W-1:0]  r2_s5;
	logic [pmgc_pkg::NUM_W-1:0] num_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			r2_s5  <= sq_s4[0] + sq_s4[1] + sq_s4[2];
			num_s5 <= num_s4;
		end
	end

	// Stage 6: capture test and softened denominator
	logic                       cap_s6;
	logic [pmgc_pkg::SQ_W-1:0]  den_s6;
	logic [pmgc_pkg::NUM_W-1:0] num_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			cap_s6 <= r2_s5 < pmgc_pkg::CAP_R2;
			den_s6 <= r2_s5 + pmgc_pkg::EPS2;
			num_s6 <= num_s5;
		end
	end

	// Distance and gain units
	logic [pmgc_pkg::ROOT_W-1:0] root_r;
	logic [pmgc_pkg::G_W-1:0]    g_g;
	logic [pmgc_pkg::G_W-1:0]    g_u;
	logic [AXES-1:0][DW-1:0]     ad_r;

	pmgc_isqrt #(
		.IN_W   (pmgc_pkg::SQ_W),
		.ROOT_W (pmgc_pkg::ROOT_W)
	) u_isqrt (
		.clk      (clk),
		.en       (en),
		.radicand (r2_s5),
		.root     (root_r)
	);

	pmgc_div #(
		.NUM_W (pmgc_pkg::NUM_W),
		.DEN_W (pmgc_pkg::SQ_W),
		.QUO_W (pmgc_pkg::G_W)
	) u_gdiv (
		.clk (clk),
		.en  (en),
		.num (num_s6),
		.den (den_s6),
		.quo (g_g)
	);

	pmgc_delay #(
		.W     (pmgc_pkg::G_W),
		.DEPTH (ST_U - ST_G)
	) u_gdly (
		.clk (clk),
		.en  (en),
		.d   (g_g),
		.q   (g_u)
	);

	pmgc_delay #(
		.W     (AXES * DW),
		.DEPTH (ST_ROOT - 2)
	) u_addly (
		.clk (clk),
		.en  (en),
		.d   (ad_s2),
		.q   (ad_r)
	);

	// Axis cosines |d|/r in Q1.30
	logic [AXES-1:0][pmgc_pkg::U_W-1:0] u_u;

	for (genvar k = 0; k < AXES; k++) begin : g_axis
		pmgc_div #(
			.NUM_W (pmgc_pkg::UNUM_W),
			.DEN_W (pmgc_pkg::ROOT_W),
			.QUO_W (pmgc_pkg::U_W)
		) u_udiv (
			.clk (clk),
			.en  (en),
			.num ({ad_r[k], {pmgc_pkg::U_FRAC{1'b0}}}),
			.den (root_r),
			.quo (u_u[k])
		);
	end

	pmgc_pkg::side_t side_i;
	logic            cap_i;

	pmgc_delay #(
		.W     ($bits(pmgc_pkg::side_t)),
		.DEPTH (ST_INC - 2)
	) u_sdly (
		.clk (clk),
		.en  (en),
		.d   (side_s2),
		.q   (side_i)
	);

	pmgc_delay #(
		.W     (1),
		.DEPTH (ST_INC - ST_CAP)
	) u_cdly (
		.clk (clk),
		.en  (en),
		.d   (cap_s6),
		.q   (cap_i)
	);

	// Stage 86: gain times cosine, split in two partial products
	logic [AXES-1:0][GH_W+pmgc_pkg::U_W-1:0] ph_s86;
	logic [AXES-1:0][GL_W+pmgc_pkg::U_W-1:0] pl_s86;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < AXES; k++) begin
				ph_s86[k] <= g_u[pmgc_pkg::G_W-1:GL_W] * u_u[k];
				pl_s86[k] <= g_u[GL_W-1:0] * u_u[k];
			end
		end
	end

	// Stage 87: velocity increment
	logic [AXES-1:0][pmgc_pkg::PROD_W-1:0] prod;
	logic [AXES-1:0][pmgc_pkg::INC_W-1:0]  inc_s87;

	always_comb begin
		for (int k = 0; k < AXES; k++) begin
			prod[k] = (pmgc_pkg::PROD_W'(ph_s86[k]) << GL_W)
				+ pmgc_pkg::PROD_W'(pl_s86[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < AXES; k++) begin
				inc_s87[k] <= prod[k][pmgc_pkg::PROD_W-1:pmgc_pkg::U_FRAC];
			end
		end
	end

	// Apply the increment with saturation, or capture, or pass through
	logic signed [pmgc_pkg::SUM_W-1:0] vs   [AXES];
	logic signed [pmgc_pkg::SUM_W-1:0] vi   [AXES];
	logic signed [pmgc_pkg::SUM_W-1:0] vsum [AXES];
	logic [AXES-1:0][CW-1:0]           vsat;
	logic                              take_cap;
	pmgc_pkg::result_t                 res;

	always_comb begin
		take_cap = side_i.act & cap_i;
		for (int k = 0; k < AXES; k++) begin
			vs[k]   = $signed({{2{side_i.vel[k][CW-1]}}, side_i.vel[k]});
			vi[k]   = $signed({{(pmgc_pkg::SUM_W - pmgc_pkg::INC_W){1'b0}}, inc_s87[k]});
			vsum[k] = side_i.neg[k] ? vs[k] - vi[k] : vs[k] + vi[k];
			if (vsum[k] > pmgc_pkg::VEL_MAX) begin
				vsat[k] = pmgc_pkg::VEL_MAX[CW-1:0];
			end else if (vsum[k] < pmgc_pkg::VEL_MIN) begin
				vsat[k] = pmgc_pkg::VEL_MIN[CW-1:0];
			end else begin
				vsat[k] = vsum[k][CW-1:0];
			end
		end
		res.cap = take_cap;
		if (take_cap) begin
			res.pos = hole_q;
			res.vel = '0;
		end else if (side_i.act) begin
			res.pos = side_i.pos;
			res.vel = vsat;
		end else begin
			res.pos = side_i.pos;
			res.vel = side_i.vel;
		end
	end

	// Output register and skid register
	logic take;

	assign take = ov_q & m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			sv_q <= 1'b0;
		end else if (sv_q) begin
			if (!ov_q || take) begin
				ov_q <= 1'b1;
				sv_q <= 1'b0;
			end
		end else if (!ov_q || take) begin
			ov_q <= vld_q[ST_INC];
		end else if (vld_q[ST_INC]) begin
			sv_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (sv_q) begin
			if (!ov_q || take) begin
				od_q <= sd_q;
			end
		end else if (!ov_q || take) begin
			od_q <= res;
		end else begin
			sd_q <= res;
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = {od_q.vel, od_q.pos};
	assign m_tuser  = od_q.cap;

	// A held skid entry implies the output register is also full
	ap_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		sv_q |-> ov_q)
		else $error("skid register full while output register empty");

	// A stalled skid entry stays put
	ap_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(sv_q && !m_tready) |=> (sv_q && $stable(sd_q)))
		else $error("skid entry changed while output stalled");

	// A captured star leaves with zero velocity
	ap_capture_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[2*AXES*CW-1:AXES*CW] == '0))
		else $error("captured star has nonzero velocity");

endmodule

`default_nettype wire

// ----- tb/sv/point_mass_gravity_capture_step_tb.sv -----
`default_nettype none

module point_mass_gravity_capture_step_tb;

	localparam int AXES      = pmgc_pkg::AXES;
	localparam int COORD_W   = pmgc_pkg::COORD_W;
	localparam int TDATA_W   = pmgc_pkg::TDATA_W;
	localparam int CFG_IDX_W = pmgc_pkg::CFG_IDX_W;
	localparam int MASS_W    = pmgc_pkg::MASS_W;
	localparam int U_FRAC    = pmgc_pkg::U_FRAC;

	localparam int CLK_HALF   = 2;
	localparam int LATENCY    = 88;
	localparam int CYCLE_CAP  = 600000;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;
	localparam logic [127:0] U64_MAX  = {64'd0, {64{1'b1}}};
	localparam logic [127:0] INC_CLIP = 128'd1 << 48;

	// One star, in or out; flag is galaxy_alive going in, captured coming out
	typedef struct packed {
		logic                         flag;
		logic [AXES-1:0][COORD_W-1:0] vel;
		logic [AXES-1:0][COORD_W-1:0] pos;
	} star_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [TDATA_W-1:0]     s_tdata;
	logic                   s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [TDATA_W-1:0]     m_tdata;
	logic                   m_tuser;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [COORD_W-1:0]     cfg_data;

	// Mirror of the block's registers
	logic                         hole_on;
	logic [MASS_W-1:0]            mass_now;
	logic [AXES-1:0][COORD_W-1:0] hole_at;

	star_t pending_stars[$];
	int    mismatches;
	int    cycles;
	int    send_idle_pct;
	int    recv_stall_pct;
	int    hold_req;
	int    hold_left;

	point_mass_gravity_capture_step dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #CLK_HALF clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("point_mass_gravity_capture_step_tb: FAIL");
			$finish;
		end
	end

	// Work out the star after one gravity step under the mirrored registers
	function automatic star_t gravity_step(star_t s);
		logic signed [COORD_W+1:0] d[AXES];
		logic [127:0] ad[AXES];
		logic [127:0] r2, r, c, g, u, p, inc;
		logic signed [65:0] v;
		star_t o;
		o = s;
		o.flag = 1'b0;
		if (!(hole_on && s.flag))
			return o;
		r2 = '0;
		for (int k = 0; k < AXES; k++) begin
			d[k] = $signed({{2{hole_at[k][COORD_W-1]}}, hole_at[k]})
				- $signed({{2{s.pos[k][COORD_W-1]}}, s.pos[k]});
			ad[k] = 128'((d[k] < 0) ? -d[k] : d[k]);
			r2 = r2 + ad[k] * ad[k];
		end
		if (r2 < 128'(pmgc_pkg::CAP_R2)) begin
			o.flag = 1'b1;
			o.pos = hole_at;
			o.vel = '0;
			return o;
		end
		r = '0;
		for (int b = 50; b >= 0; b--) begin
			c = r | (128'd1 << b);
			if (r2 >= c * c)
				r = c;
		end
		g = (128'(mass_now) * 128'(pmgc_pkg::KGAIN)) / (r2 + 128'(pmgc_pkg::EPS2));
		if (g > U64_MAX)
			g = U64_MAX;
		for (int k = 0; k < AXES; k++) begin
			u = (ad[k] << U_FRAC) / r;
			if (u > U64_MAX)
				u = U64_MAX;
			p = g * u;
			inc = (p >> U_FRAC) & U64_MAX;
			if (inc > INC_CLIP)
				inc = INC_CLIP;
			v = $signed({{18{s.vel[k][COORD_W-1]}}, s.vel[k]});
			if (d[k] < 0)
				v = v - $signed({2'b00, inc[63:0]});
			else
				v = v + $signed({2'b00, inc[63:0]});
			if (v > 66'sh7FFF_FFFF_FFFF)
				v = 66'sh7FFF_FFFF_FFFF;
			if (v < -66'sh8000_0000_0000)
				v = -66'sh8000_0000_0000;
			o.vel[k] = v[COORD_W-1:0];
		end
		return o;
	endfunction

	task automatic report(string what, int axis, logic [COORD_W-1:0] got,
			logic [COORD_W-1:0] want);
		$display("mismatch %s[%0d]: got %h want %h at cycle %0d", what, axis, got, want,
			cycles);
		mismatches++;
	endtask

	// Check each result transfer
	always @(posedge clk) begin
		star_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_stars.size() == 0) begin
				report("unexpected", 0, m_tdata[COORD_W-1:0], '0);
			end else begin
				want = pending_stars.pop_front();
				for (int k = 0; k < AXES; k++) begin
					if (m_tdata[k*COORD_W +: COORD_W] !== want.pos[k])
						report("pos", k, m_tdata[k*COORD_W +: COORD_W], want.pos[k]);
					if (m_tdata[(AXES+k)*COORD_W +: COORD_W] !== want.vel[k])
						report("vel", k, m_tdata[(AXES+k)*COORD_W +: COORD_W],
							want.vel[k]);
				end
				if (m_tuser !== want.flag)
					report("captured", 0, 48'(m_tuser), 48'(want.flag));
			end
		end
	end

	// Pick the next ready level; count down a requested long hold
	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic send_star(star_t s);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {s.vel, s.pos};
		s_tuser <= s.flag;
		do @(posedge clk); while (!s_tready);
		pending_stars.push_back(gravity_step(s));
	endtask

	// Stop offering and wait for every outstanding result
	task automatic drain;
		s_tvalid <= 1'b0;
		while (pending_stars.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 12) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			pmgc_pkg::CFG_ENABLE: hole_on = val[0];
			pmgc_pkg::CFG_MASS:   mass_now = val[MASS_W-1:0];
			pmgc_pkg::CFG_HOLE_X: hole_at[0] = val;
			pmgc_pkg::CFG_HOLE_Y: hole_at[1] = val;
			pmgc_pkg::CFG_HOLE_Z: hole_at[2] = val;
			default: ;
		endcase
	endtask

	task automatic end_writes;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [COORD_W-1:0] rand48();
		return COORD_W'({$urandom, $urandom});
	endfunction

	// Signed random offset below 2^sh in magnitude
	function automatic logic [COORD_W-1:0] rand_offset(int sh);
		logic [COORD_W-1:0] m;
		m = rand48() & ((48'd1 << sh) - 48'd1);
		return $urandom_range(1) ? -m : m;
	endfunction

	function automatic star_t rand_star();
		star_t s;
		for (int k = 0; k < AXES; k++) begin
			case ($urandom_range(5))
				0: s.pos[k] = rand48();
				1: s.pos[k] = hole_at[k] + rand_offset($urandom_range(14, 20));
				default: s.pos[k] = hole_at[k] + rand_offset($urandom_range(18, 34));
			endcase
			case ($urandom_range(4))
				0: s.vel[k] = rand48();
				1: s.vel[k] = $urandom_range(1) ? 48'h7FFF_FFFF_FFF0 + 48'($urandom_range(15))
					: 48'h8000_0000_0010 - 48'($urandom_range(15));
				default: s.vel[k] = rand_offset($urandom_range(0, 30));
			endcase
		end
		s.flag = ($urandom_range(9) != 0);
		return s;
	endfunction

	task automatic random_config;
		logic [COORD_W-1:0] junk;
		junk = rand48() & ~48'hFF_FFFF;
		write_reg(pmgc_pkg::CFG_ENABLE,
			($urandom_range(7) != 0) ? 48'd1 | (rand48() & ~48'd1) : 48'd0);
		case ($urandom_range(3))
			0: write_reg(pmgc_pkg::CFG_MASS, junk);
			1: write_reg(pmgc_pkg::CFG_MASS, junk | 48'hFF_FFFF);
			default: write_reg(pmgc_pkg::CFG_MASS, rand48());
		endcase
		for (int k = 0; k < AXES; k++)
			write_reg(pmgc_pkg::cfg_idx_t'(pmgc_pkg::CFG_HOLE_X + k),
				$urandom_range(1) ? rand48() : rand_offset($urandom_range(20, 40)));
		write_reg(CFG_UNUSED_LO + CFG_IDX_W'($urandom_range(2)), rand48());
		end_writes();
	endtask

	task automatic run_random(int count, int idle, int stall);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		random_config();
		for (int i = 0; i < count; i++)
			send_star(rand_star());
		drain();
	endtask

	task automatic test_directed;
		star_t s;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		// reset values: hole at origin, mass 1e6, enabled
		s = '0; s.flag = 1'b1;
		send_star(s);                                   // zero distance
		s.pos[0] = 48'd838860; send_star(s);            // just inside radius
		s.pos[0] = 48'd838861; send_star(s);            // on radius, not captured
		s.pos = {48'd0, 48'd600000, 48'd600000}; send_star(s);
		s.pos = {48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF};
		send_star(s);
		s.pos = {48'd0, 48'd0, 48'd1 << 24};
		s.vel = {48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'h8000_0000_0000};
		send_star(s);                                   // extreme velocities, pulled toward hole
		s.flag = 1'b0; send_star(s);                    // dead galaxy
		drain();
		write_reg(pmgc_pkg::CFG_MASS, 48'hFFFF_FFFF_FFFF);
		write_reg(pmgc_pkg::CFG_HOLE_X, 48'h7FFF_FFFF_FFFF);
		write_reg(pmgc_pkg::CFG_HOLE_Y, 48'h8000_0000_0000);
		write_reg(pmgc_pkg::CFG_HOLE_Z, 48'd1 << 20);
		write_reg(CFG_UNUSED_HI, 48'd0);
		end_writes();
		s.flag = 1'b1;
		s.pos = {48'd1 << 20, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF};
		s.vel = {48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'h0};
		send_star(s);                                   // at hole extremes
		s.pos[0] = 48'h7FFF_FFFF_FFFF - 48'd900000; send_star(s);
		s.pos[0] = 48'h7FFF_FFF0_0000; send_star(s);
		s.pos = {48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000};
		send_star(s);                                   // farthest point
		s.pos = {48'd1 << 20, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF - 48'd1000000};
		s.vel = {48'h0, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF};
		send_star(s);
		drain();
		write_reg(pmgc_pkg::CFG_MASS, 48'd0);
		end_writes();
		send_star(s);                                   // no mass
		drain();
		write_reg(pmgc_pkg::CFG_ENABLE, 48'hFFFF_FFFF_FFFE);  // bit 0 low: disabled
		end_writes();
		s.pos = {48'd1 << 20, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF};
		send_star(s);
		s.flag = 1'b0; send_star(s);
		drain();
	endtask

	task automatic test_no_idle;         run_random(350, 0, 0);   endtask
	task automatic test_sender_idle;     run_random(350, 77, 0);  endtask
	task automatic test_receiver_stall;  run_random(350, 0, 77);  endtask
	task automatic test_both_idle;       run_random(350, 20, 20); endtask

	// Hold the output off long enough that the pipeline fills and stalls input
	task automatic test_backpressure;
		send_idle_pct = 0;
		recv_stall_pct = 10;
		random_config();
		hold_req = 400;
		for (int i = 0; i < 400; i++)
			send_star(rand_star());
		drain();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mismatches = 0;
		cycles = 0;
		hold_req = 0;
		hold_left = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hole_on = 1'b1;
		mass_now = pmgc_pkg::MASS_RESET;
		hole_at = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_no_idle();
		test_sender_idle();
		test_receiver_stall();
		test_both_idle();
		test_backpressure();
		if (mismatches == 0 && pending_stars.size() == 0)
			$display("point_mass_gravity_capture_step_tb: PASS");
		else
			$display("point_mass_gravity_capture_step_tb: FAIL");
		$finish;
	end

endmodule

`default_nettype wire
